FILE: rtl/core/circular_queue_macros.svh
// Assertion macros shared by the circular queue checker.
// Needs signals named clk and arst_n in the scope where a macro is used.
`ifndef CIRCULAR_QUEUE_MACROS_SVH
`define CIRCULAR_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("circular_queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define CQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("circular_queue check failed");

`endif

FILE: rtl/core/cq_pkg.sv
// Types and constants of the circular queue.
// Used by the controller, the top level and the checker; depends on nothing.
package cq_pkg;

	localparam int CQ_DEPTH = 64;
	localparam int CQ_IDX_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
	localparam int CQ_DATA_W = 32;
	localparam int CQ_CAP_W = 7;
	localparam int CQ_CAP_RESET = 64;

	typedef enum logic [1:0] {
		CMD_ENQ  = 2'd0,
		CMD_DEQ  = 2'd1,
		CMD_SHOW = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_FULL      = 3'd1,
		ST_DEQUEUED  = 3'd2,
		ST_UNDERFLOW = 3'd3,
		ST_SHOWN     = 3'd4
	} status_t;

	// Result handed from the controller to the output register.
	typedef struct packed {
		logic    load;
		status_t status;
		logic    from_mem;
		logic    echo;
		logic    last;
	} res_t;

endpackage

FILE: rtl/core/cq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Self-contained; no package needed.
module cq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/cq_ctrl.sv
// Queue controller: head, tail and empty flag, command decode, display walk.
// Depends on cq_pkg; drives the ports of the slot RAM.
module cq_ctrl
	import cq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CQ_CAP_W-1:0]  cap,
	input  logic                 clear,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           cmd,
	input  logic                 out_free,
	output logic                 ram_we,
	output logic [CQ_IDX_W-1:0]  ram_waddr,
	output logic                 ram_re,
	output logic [CQ_IDX_W-1:0]  ram_raddr,
	output res_t                 res
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t              state_q, state_d;
	logic [CQ_IDX_W-1:0] head_q, head_d;
	logic [CQ_IDX_W-1:0] tail_q, tail_d;
	logic                empty_q, empty_d;
	logic                show_q, show_d;
	logic [CQ_IDX_W-1:0] disp_q, disp_d;
	logic [CQ_IDX_W-1:0] cnt_q, cnt_d;
	logic                accept;
	logic [CQ_IDX_W-1:0] tail_nxt, head_nxt, disp_nxt;
	logic                fin;

	function automatic logic [CQ_IDX_W-1:0] step(input logic [CQ_IDX_W-1:0] idx,
		input logic [CQ_CAP_W-1:0] c);
		logic [CQ_IDX_W:0] n;
		n = {1'b0, idx} + 1'b1;
		return (CQ_CAP_W'(n) >= c) ? '0 : n[CQ_IDX_W-1:0];
	endfunction

	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;
	assign tail_nxt = step(tail_q, cap);
	assign head_nxt = step(head_q, cap);
	assign disp_nxt = step(disp_q, cap);
	assign fin      = (disp_q == tail_q) || (cnt_q == CQ_IDX_W'(CQ_DEPTH - 1));

	// Writes happen only in idle and reads complete before the next item is taken,
	// so one slot is never written and read in the same cycle.
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		empty_d   = empty_q;
		show_d    = show_q;
		disp_d    = disp_q;
		cnt_d     = cnt_q;
		ram_we    = 1'b0;
		ram_waddr = tail_nxt;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		res       = '0;
		res.status = ST_INSERTED;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd_t'(cmd))
						CMD_ENQ: begin
							res.load = 1'b1;
							res.last = 1'b1;
							if (empty_q) begin
								ram_we    = 1'b1;
								ram_waddr = '0;
								head_d    = '0;
								tail_d    = '0;
								empty_d   = 1'b0;
								res.echo  = 1'b1;
							end else if (tail_nxt == head_q) begin
								res.status = ST_FULL;
							end else begin
								ram_we   = 1'b1;
								tail_d   = tail_nxt;
								res.echo = 1'b1;
							end
						end
						CMD_DEQ: begin
							if (empty_q) begin
								res.load   = 1'b1;
								res.last   = 1'b1;
								res.status = ST_UNDERFLOW;
							end else begin
								ram_re  = 1'b1;
								show_d  = 1'b0;
								state_d = S_READ;
								if (head_q == tail_q) begin
									head_d  = '0;
									tail_d  = '0;
									empty_d = 1'b1;
								end else begin
									head_d = head_nxt;
								end
							end
						end
						CMD_SHOW: begin
							if (empty_q) begin
								res.load   = 1'b1;
								res.last   = 1'b1;
								res.status = ST_UNDERFLOW;
							end else begin
								ram_re  = 1'b1;
								show_d  = 1'b1;
								disp_d  = head_q;
								cnt_d   = '0;
								state_d = S_READ;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				if (out_free) begin
					res.load     = 1'b1;
					res.from_mem = 1'b1;
					if (!show_q) begin
						res.status = ST_DEQUEUED;
						res.last   = 1'b1;
						state_d    = S_IDLE;
					end else begin
						res.status = ST_SHOWN;
						res.last   = fin;
						if (fin) begin
							state_d = S_IDLE;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = disp_nxt;
							disp_d    = disp_nxt;
							cnt_d     = cnt_q + 1'b1;
						end
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
			show_q  <= 1'b0;
			disp_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			show_q  <= show_d;
			disp_q  <= disp_d;
			cnt_q   <= cnt_d;
			if (clear) begin
				head_q  <= '0;
				tail_q  <= '0;
				empty_q <= 1'b1;
			end else begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				empty_q <= empty_d;
			end
		end
	end

endmodule

FILE: rtl/core/circular_queue.sv
// Top level of the circular queue: capacity register, slot RAM, controller
// and output register. Depends on cq_pkg, cq_ram and cq_ctrl.
//
// Usage: an input item (cmd, data_in) is taken when in_valid is high and
// in_stall is low; a result (status, data_out, last) is taken when out_valid
// is high and out_stall is low. Every item but the unused command gives at
// least one result, the final one marked by last.
// Enqueue, and dequeue or display on an empty queue, is answered from the
// output register in the cycle after the item is taken, and a new item can
// be taken every cycle while out_stall holds no result. Dequeue needs the
// slot RAM read: its result passes through the RAM read register and then
// the output register, and the next item is taken after it is loaded.
// Display walks the RAM from head to tail, one element per cycle unless the
// receiver stalls; in_stall stays high until the last one is loaded.
// Reset empties the queue and sets the capacity to 64; slot contents are not
// cleared and need no clearing pass. Writing capacity (clamped to 1..64) also
// empties the queue. While the receiver holds out_stall, the result and all
// work behind it wait, and in_stall is raised.
module circular_queue
	import cq_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        capacity_we,
	input  logic [CQ_CAP_W-1:0]         capacity,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  cmd,
	input  logic signed [CQ_DATA_W-1:0] data_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  status,
	output logic signed [CQ_DATA_W-1:0] data_out,
	output logic                        last
);

	logic [CQ_CAP_W-1:0]  cap_q;
	logic [CQ_CAP_W-1:0]  cap_eff;
	logic                 out_free;
	logic                 ram_we, ram_re;
	logic [CQ_IDX_W-1:0]  ram_waddr, ram_raddr;
	logic [CQ_DATA_W-1:0] ram_rdata;
	res_t                 res;
	logic                 out_valid_q;
	status_t              status_q;
	logic [CQ_DATA_W-1:0] data_q;
	logic                 last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CQ_CAP_W'(CQ_CAP_RESET);
		end else if (capacity_we) begin
			cap_q <= capacity;
		end
	end

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CQ_CAP_W'(1);
		end else if (cap_q > CQ_CAP_W'(CQ_DEPTH)) begin
			cap_eff = CQ_CAP_W'(CQ_DEPTH);
		end else begin
			cap_eff = cap_q;
		end
	end

	cq_ram #(
		.WIDTH (CQ_DATA_W),
		.DEPTH (CQ_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (data_in),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cap       (cap_eff),
		.clear     (capacity_we),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_free  (out_free),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.res       (res)
	);

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			status_q <= res.status;
			last_q   <= res.last;
			if (res.from_mem) begin
				data_q <= ram_rdata;
			end else if (res.echo) begin
				data_q <= data_in;
			end else begin
				data_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data_out  = $signed(data_q);
	assign last      = last_q;

endmodule

FILE: rtl/core/cq_chk.sv
// Port-level checker for the circular queue, bound to the top level.
// Depends on cq_pkg and circular_queue_macros.svh.
`include "circular_queue_macros.svh"

module cq_chk
	import cq_pkg::*;
(
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [1:0]                  cmd,
	input logic signed [CQ_DATA_W-1:0] data_in,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [2:0]                  status,
	input logic signed [CQ_DATA_W-1:0] data_out,
	input logic                        last
);

	`CQ_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
	`CQ_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(status) && $stable(data_out) && $stable(last))
	// An enqueue is answered in the next cycle, echoing its value unless rejected.
	`CQ_ASSERT_NXT(a_enq_echo, in_valid && !in_stall && (cmd == CMD_ENQ), out_valid && last && ((status == ST_INSERTED && data_out == $past(data_in)) || status == ST_FULL))
	`CQ_ASSERT_IMP(a_zero_data, out_valid && (status == ST_FULL || status == ST_UNDERFLOW), data_out == '0 && last)
	// While a display still has elements to send, no new item is taken.
	`CQ_ASSERT_IMP(a_show_busy, out_valid && (status == ST_SHOWN) && !last, in_stall)

endmodule

bind circular_queue cq_chk u_cq_chk (.*);

FILE: dv/circular_queue_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the circular queue: predicts the results of every accepted
// item and compares them with the results taken from the output channel.
// Depends on cq_pkg for the command and status codes and the widths.
module circular_queue_checker
	import cq_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        capacity_we,
	input  logic [CQ_CAP_W-1:0]         capacity,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [1:0]                  cmd,
	input  logic signed [CQ_DATA_W-1:0] data_in,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [2:0]                  status,
	input  logic signed [CQ_DATA_W-1:0] data_out,
	input  logic                        last,
	output int                          fail_count,
	output int                          pending,
	output int                          checked_count,
	output int                          full_count,
	output int                          underflow_count
);

	typedef struct packed {
		status_t                     status;
		logic signed [CQ_DATA_W-1:0] data;
		logic                        last;
	} queue_result_t;

	queue_result_t               expected_q[$];
	logic signed [CQ_DATA_W-1:0] slot_mem [CQ_DEPTH];
	logic [CQ_IDX_W-1:0]         head_idx;
	logic [CQ_IDX_W-1:0]         tail_idx;
	logic                        queue_empty;
	logic [CQ_CAP_W-1:0]         cap_reg;

	// A capacity of zero behaves as one, anything above the depth as the depth.
	function automatic int active_cap();
		if (cap_reg == 0)
			return 1;
		if (int'(cap_reg) > CQ_DEPTH)
			return CQ_DEPTH;
		return int'(cap_reg);
	endfunction

	function automatic logic [CQ_IDX_W-1:0] next_idx(input logic [CQ_IDX_W-1:0] i);
		int n;
		n = int'(i) + 1;
		if (n >= active_cap())
			return '0;
		return n[CQ_IDX_W-1:0];
	endfunction

	task automatic push_expect(input status_t s, input logic signed [CQ_DATA_W-1:0] d,
			input logic l);
		queue_result_t r;
		r.status = s;
		r.data = d;
		r.last = l;
		expected_q.push_back(r);
	endtask

	task automatic predict_item(input cmd_t c, input logic signed [CQ_DATA_W-1:0] v);
		logic [CQ_IDX_W-1:0] nt;
		logic [CQ_IDX_W-1:0] i;
		int                  k;
		logic                fin;
		case (c)
			CMD_ENQ: begin
				if (queue_empty) begin
					head_idx = '0;
					tail_idx = '0;
					slot_mem[0] = v;
					queue_empty = 1'b0;
					push_expect(ST_INSERTED, v, 1'b1);
				end else begin
					nt = next_idx(tail_idx);
					if (nt == head_idx) begin
						push_expect(ST_FULL, '0, 1'b1);
					end else begin
						tail_idx = nt;
						slot_mem[nt] = v;
						push_expect(ST_INSERTED, v, 1'b1);
					end
				end
			end
			CMD_DEQ: begin
				if (queue_empty) begin
					push_expect(ST_UNDERFLOW, '0, 1'b1);
				end else begin
					push_expect(ST_DEQUEUED, slot_mem[head_idx], 1'b1);
					if (head_idx == tail_idx) begin
						head_idx = '0;
						tail_idx = '0;
						queue_empty = 1'b1;
					end else begin
						head_idx = next_idx(head_idx);
					end
				end
			end
			CMD_SHOW: begin
				if (queue_empty) begin
					push_expect(ST_UNDERFLOW, '0, 1'b1);
				end else begin
					i = head_idx;
					fin = 1'b0;
					for (k = 0; k < CQ_DEPTH && !fin; k++) begin
						fin = (i == tail_idx) || (k == CQ_DEPTH - 1);
						push_expect(ST_SHOWN, slot_mem[i], fin);
						i = next_idx(i);
					end
				end
			end
			default: begin
				// The unused code gives no result and leaves the queue alone.
			end
		endcase
	endtask

	task automatic note_failure(input string msg);
		if (fail_count < 10)
			$display("%s", msg);
		fail_count++;
	endtask

	task automatic check_result();
		queue_result_t e;
		if (expected_q.size() == 0) begin
			note_failure($sformatf("%0t: unexpected result: status %0d data %0d last %0b",
				$time, status, data_out, last));
		end else begin
			e = expected_q.pop_front();
			checked_count++;
			if (status !== 3'(e.status) || data_out !== e.data || last !== e.last) begin
				note_failure({
					$sformatf("%0t: mismatch: expected status %s data %0d last %0b",
						$time, e.status.name(), e.data, e.last),
					$sformatf(", got status %0d data %0d last %0b",
						status, data_out, last)});
			end
			if (e.status == ST_FULL)
				full_count++;
			if (e.status == ST_UNDERFLOW)
				underflow_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q.delete();
			head_idx = '0;
			tail_idx = '0;
			queue_empty = 1'b1;
			cap_reg = CQ_CAP_W'(CQ_CAP_RESET);
			pending = 0;
			fail_count = 0;
			checked_count = 0;
			full_count = 0;
			underflow_count = 0;
		end else begin
			// A capacity write always empties the queue.
			if (capacity_we) begin
				cap_reg = capacity;
				head_idx = '0;
				tail_idx = '0;
				queue_empty = 1'b1;
			end
			if (in_valid && !in_stall)
				predict_item(cmd_t'(cmd), data_in);
			if (out_valid && !out_stall)
				check_result();
			pending = expected_q.size();
		end
	end

endmodule

FILE: dv/circular_queue_test.sv
`timescale 1ns / 100ps
// Top of the circular queue testbench: clock, reset, item and capacity stimulus,
// output stalls, watchdog and verdict. Depends on cq_pkg, circular_queue and
// circular_queue_checker.
module circular_queue_test
	import cq_pkg::*;
();

	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE = 8;
	localparam int DRAIN = 20;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        capacity_we = 1'b0;
	logic [CQ_CAP_W-1:0]         capacity = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [1:0]                  cmd = CMD_NONE;
	logic signed [CQ_DATA_W-1:0] data_in = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [2:0]                  status;
	logic signed [CQ_DATA_W-1:0] data_out;
	logic                        last;

	int fail_count;
	int pending;
	int checked_count;
	int full_count;
	int underflow_count;
	int items_sent = 0;
	int cap_writes = 0;
	int idle_cycles = 0;

	bit calm = 1'b0;
	bit steady_send = 1'b0;
	bit hold_req = 1'b0;

	always #1 clk = ~clk;

	circular_queue DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.capacity_we(capacity_we),
		.capacity   (capacity),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.data_in    (data_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.data_out   (data_out),
		.last       (last)
	);

	circular_queue_checker cq_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.capacity_we    (capacity_we),
		.capacity       (capacity),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.data_in        (data_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.data_out       (data_out),
		.last           (last),
		.fail_count     (fail_count),
		.pending        (pending),
		.checked_count  (checked_count),
		.full_count     (full_count),
		.underflow_count(underflow_count)
	);

	function automatic logic signed [CQ_DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_t pick_cmd(input int enq_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return CMD_NONE;
		if (r < 11)
			return CMD_SHOW;
		if ($urandom_range(0, 99) < enq_pct)
			return CMD_ENQ;
		return CMD_DEQ;
	endfunction

	task automatic put_item(input cmd_t c, input logic signed [CQ_DATA_W-1:0] d);
		int gap;
		if (!calm && !steady_send && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		data_in <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	// The pending count moves at the rising edge, so it is read on the falling one.
	task automatic wait_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic set_capacity(input logic [CQ_CAP_W-1:0] v);
		wait_results();
		// Unused commands give no result but may still be in flight.
		repeat (SETTLE) @(posedge clk);
		capacity_we <= 1'b1;
		capacity <= v;
		@(posedge clk);
		capacity_we <= 1'b0;
		cap_writes++;
	endtask

	task automatic run_random(input int count, input int enq_pct);
		int n;
		for (n = 0; n < count; n++)
			put_item(pick_cmd(enq_pct), pick_value());
	endtask

	// Receiver side: random stall bursts, and one long hold-off on request.
	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout after %0d cycles with no item moving", IDLE_LIMIT);
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		int                  p;
		int                  n;
		logic [CQ_CAP_W-1:0] cap_plan [10];
		cap_plan = '{7'd3, 7'd64, 7'd127, 7'd1, 7'd7, 7'd100, 7'd0, 7'd2, 7'd64, 7'd16};
		cap_plan[6] = CQ_CAP_W'($urandom_range(1, 127));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset capacity: empty queue, extremes, wrap to empty.
		put_item(CMD_SHOW, '0);
		put_item(CMD_DEQ, '0);
		put_item(CMD_ENQ, 32'sh7fff_ffff);
		put_item(CMD_ENQ, 32'sh8000_0000);
		put_item(CMD_ENQ, '0);
		put_item(CMD_ENQ, -32'sd1);
		put_item(CMD_SHOW, '0);
		put_item(CMD_NONE, 32'sh5555_aaaa);
		put_item(CMD_DEQ, '0);
		put_item(CMD_DEQ, '0);
		put_item(CMD_DEQ, '0);
		put_item(CMD_DEQ, '0);
		put_item(CMD_DEQ, '0);
		put_item(CMD_ENQ, 32'sd1);
		put_item(CMD_DEQ, '0);

		// A zero capacity behaves as a single slot.
		set_capacity('0);
		put_item(CMD_ENQ, 32'sh1234_5678);
		put_item(CMD_ENQ, 32'sh0bad_cafe);
		put_item(CMD_SHOW, '0);
		put_item(CMD_DEQ, '0);
		put_item(CMD_SHOW, '0);

		for (p = 0; p < 10; p++) begin
			set_capacity(cap_plan[p]);
			run_random(30, (p % 3 == 0) ? 75 : ((p % 3 == 1) ? 40 : 60));
		end

		// The receiver holds off while the sender keeps offering items, so the input
		// backs up; more enqueues follow than the queue has slots, so it fills up.
		set_capacity(7'd64);
		steady_send = 1'b1;
		hold_req = 1'b1;
		for (n = 0; n < 75; n++)
			put_item(CMD_ENQ, pick_value());
		put_item(CMD_SHOW, '0);
		for (n = 0; n < 10; n++)
			put_item(CMD_DEQ, '0);
		put_item(CMD_SHOW, '0);
		steady_send = 1'b0;
		wait_results();
		run_random(40, 50);

		// Last part: no idling on either side.
		set_capacity(7'd5);
		calm = 1'b1;
		run_random(60, 60);

		wait_results();
		repeat (DRAIN) @(posedge clk);

		$display("%0d items sent over %0d capacity settings, %0d results checked",
			items_sent, cap_writes, checked_count);
		$display("%0d full rejections and %0d underflows seen", full_count, underflow_count);
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
